[design/nftk_pkg.sv]
// Shared types and constants for the name frequency table with top-k report.
`default_nettype none
package nftk_pkg;

  localparam int unsigned NAME_W    = 64;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned RANK_W    = 3;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned NAME_BYTES = 16;
  localparam int unsigned TOP_COUNT  = 5;
  localparam int unsigned TOP_W      = $clog2(TOP_COUNT + 1);

  localparam int unsigned IN_DATA_W  = 2 * NAME_W;
  localparam int unsigned OUT_FIELDS_W = 2 * NAME_W + CNT_W + RANK_W + CNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [0:0] {
    REQ_RECORD = 1'b0,
    REQ_REPORT = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_MATCH   = 3'd0,
    STATUS_NEW     = 3'd1,
    STATUS_DROPPED = 3'd2,
    STATUS_TOP     = 3'd3,
    STATUS_EMPTY   = 3'd4
  } status_e;

endpackage
`default_nettype wire

[design/name_frequency_table_top_k_core.sv]
// Name frequency table: lookup and append of names, and a top-k report by count.
//
//  channel  | dir | tdata                                            | tuser    | tlast
//  s_axis   | in  | name_high, name_low                              | req_type | -
//  m_axis   | out | out_name_high, out_name_low, entry_count, rank,  | status   | last
//           |     | total_seen                                       |          |
//
// One shared read port walks the table one entry a cycle with a single compare unit.
// A record item walks the filled entries and answers on the first match; on a miss it
// appends the name, or drops it when the table is full, once the walk ends. A report
// item walks the table once per result, up to five results, starting after acceptance
// or after the previous result is taken; an empty table answers in the cycle right after acceptance.
// The input is ready again the cycle after the final result is taken; m_axis_tready
// low holds the block in place. Reset clears the fill count and the total; the name
// and count memories are not cleared, since only filled entries are ever read.
`default_nettype none
module name_frequency_table_top_k_core #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  // name_high [63:0], name_low [127:64]
  input  wire logic [nftk_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // req_type [0]
  input  wire logic                               s_axis_tuser,
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // out_name_high [63:0], out_name_low [127:64], entry_count [159:128],
  // rank [162:160], total_seen [194:163], zero fill [199:195]
  output      logic [nftk_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status [2:0]
  output      logic [nftk_pkg::STATUS_W-1:0]      m_axis_tuser,
  output      logic                               m_axis_tlast
);

  localparam int unsigned AW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned NCW = (CW > nftk_pkg::TOP_W) ? CW : nftk_pkg::TOP_W;
  localparam int unsigned PAD_W = nftk_pkg::OUT_DATA_W - nftk_pkg::OUT_FIELDS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RANK,
    ST_OUT
  } state_e;

  // Table memories.
  logic [nftk_pkg::NAME_W-1:0] key_hi_mem [TABLE_ENTRIES];
  logic [nftk_pkg::NAME_W-1:0] key_lo_mem [TABLE_ENTRIES];
  logic [nftk_pkg::CNT_W-1:0]  count_mem  [TABLE_ENTRIES];

  logic [nftk_pkg::NAME_W-1:0] rd_hi_q, rd_lo_q;
  logic [nftk_pkg::CNT_W-1:0]  rd_cnt_q;
  logic [AW-1:0]               rd_addr;

  logic                        wr_key_en, wr_cnt_en;
  logic [AW-1:0]               wr_addr;
  logic [nftk_pkg::CNT_W-1:0]  wr_cnt;

  // Control and working registers.
  state_e                      state_q, state_d;
  logic [CW-1:0]               used_q, used_d;
  logic [nftk_pkg::CNT_W-1:0]  total_q, total_d;
  logic [CW-1:0]               iss_q, iss_d;
  logic                        pend_q, pend_d;
  logic [AW-1:0]               pidx_q, pidx_d;
  logic                        more_q, more_d;
  logic [nftk_pkg::TOP_W-1:0]  n_q, n_d;

  logic [nftk_pkg::NAME_W-1:0] name_hi_q, name_hi_d, name_lo_q, name_lo_d;
  logic                        found_q, found_d, have_prev_q, have_prev_d;
  logic [nftk_pkg::CNT_W-1:0]  best_cnt_q, best_cnt_d, prev_cnt_q, prev_cnt_d;
  logic [AW-1:0]               best_idx_q, best_idx_d, prev_idx_q, prev_idx_d;
  logic [nftk_pkg::NAME_W-1:0] best_hi_q, best_hi_d, best_lo_q, best_lo_d;

  logic                        o_valid_q, o_valid_d, o_last_q, o_last_d;
  nftk_pkg::status_e           o_status_q, o_status_d;
  logic [nftk_pkg::NAME_W-1:0] o_hi_q, o_hi_d, o_lo_q, o_lo_d;
  logic [nftk_pkg::CNT_W-1:0]  o_cnt_q, o_cnt_d;
  logic [nftk_pkg::RANK_W-1:0] o_rank_q, o_rank_d;

  logic [2*nftk_pkg::NAME_W-1:0] canon;
  logic                        scan_end, hit, eligible;
  logic [nftk_pkg::TOP_W-1:0]  n_inc;
  logic                        rank_last;

  // A name ends at its first zero byte; every byte from there on is cleared.
  function automatic logic [2*nftk_pkg::NAME_W-1:0] canon_name(
    input logic [nftk_pkg::NAME_W-1:0] hi,
    input logic [nftk_pkg::NAME_W-1:0] lo
  );
    logic [2*nftk_pkg::NAME_W-1:0] w;
    logic                          ended;
    w = {hi, lo};
    ended = 1'b0;
    for (int k = 0; k < 16; k++) begin
      if (k >= int'(nftk_pkg::NAME_BYTES) || w[127-8*k -: 8] == 8'h00) begin
        ended = 1'b1;
      end
      if (ended) begin
        w[127-8*k -: 8] = 8'h00;
      end
    end
    return w;
  endfunction

  assign canon    = canon_name(s_axis_tdata[63:0], s_axis_tdata[127:64]);
  assign rd_addr  = iss_q[AW-1:0];
  assign scan_end = !pend_q && (iss_q >= used_q);
  assign hit      = pend_q && (rd_hi_q == name_hi_q) && (rd_lo_q == name_lo_q);
  assign eligible = !have_prev_q || (rd_cnt_q < prev_cnt_q) ||
                    ((rd_cnt_q == prev_cnt_q) && (pidx_q > prev_idx_q));
  assign n_inc    = n_q + nftk_pkg::TOP_W'(1);
  assign rank_last = (NCW'(n_inc) == NCW'(nftk_pkg::TOP_COUNT)) ||
                     (NCW'(n_inc) == NCW'(used_q));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tuser  = o_status_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, total_q, o_rank_q, o_cnt_q, o_lo_q, o_hi_q};

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    total_d     = total_q;
    iss_d       = iss_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    more_d      = more_q;
    n_d         = n_q;
    name_hi_d   = name_hi_q;
    name_lo_d   = name_lo_q;
    found_d     = found_q;
    have_prev_d = have_prev_q;
    best_cnt_d  = best_cnt_q;
    best_idx_d  = best_idx_q;
    best_hi_d   = best_hi_q;
    best_lo_d   = best_lo_q;
    prev_cnt_d  = prev_cnt_q;
    prev_idx_d  = prev_idx_q;
    o_valid_d   = o_valid_q;
    o_last_d    = o_last_q;
    o_status_d  = o_status_q;
    o_hi_d      = o_hi_q;
    o_lo_d      = o_lo_q;
    o_cnt_d     = o_cnt_q;
    o_rank_d    = o_rank_q;
    wr_key_en   = 1'b0;
    wr_cnt_en   = 1'b0;
    wr_addr     = pidx_q;
    wr_cnt      = rd_cnt_q;

    // Shared walk: issue one read a cycle while filled entries remain.
    if (state_q == ST_SCAN || state_q == ST_RANK) begin
      if (iss_q < used_q) begin
        pend_d = 1'b1;
        pidx_d = iss_q[AW-1:0];
        iss_d  = iss_q + CW'(1);
      end else begin
        pend_d = 1'b0;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          name_hi_d = canon[127:64];
          name_lo_d = canon[63:0];
          iss_d     = '0;
          pend_d    = 1'b0;
          if (s_axis_tuser == nftk_pkg::REQ_RECORD) begin
            if (total_q != nftk_pkg::CNT_MAX) begin
              total_d = total_q + nftk_pkg::CNT_W'(1);
            end
            state_d = ST_SCAN;
          end else if (used_q == '0) begin
            o_valid_d  = 1'b1;
            o_status_d = nftk_pkg::STATUS_EMPTY;
            o_hi_d     = '0;
            o_lo_d     = '0;
            o_cnt_d    = '0;
            o_rank_d   = '0;
            o_last_d   = 1'b1;
            more_d     = 1'b0;
            state_d    = ST_OUT;
          end else begin
            n_d         = '0;
            have_prev_d = 1'b0;
            found_d     = 1'b0;
            state_d     = ST_RANK;
          end
        end
      end
      ST_SCAN: begin
        o_hi_d   = name_hi_q;
        o_lo_d   = name_lo_q;
        o_rank_d = '0;
        o_last_d = 1'b1;
        more_d   = 1'b0;
        if (hit) begin
          wr_cnt_en  = 1'b1;
          wr_addr    = pidx_q;
          wr_cnt     = (rd_cnt_q == nftk_pkg::CNT_MAX) ? rd_cnt_q
                                                       : rd_cnt_q + nftk_pkg::CNT_W'(1);
          o_cnt_d    = wr_cnt;
          o_status_d = nftk_pkg::STATUS_MATCH;
          o_valid_d  = 1'b1;
          state_d    = ST_OUT;
        end else if (scan_end) begin
          if (used_q < CW'(TABLE_ENTRIES)) begin
            wr_key_en  = 1'b1;
            wr_cnt_en  = 1'b1;
            wr_addr    = used_q[AW-1:0];
            wr_cnt     = nftk_pkg::CNT_W'(1);
            used_d     = used_q + CW'(1);
            o_cnt_d    = nftk_pkg::CNT_W'(1);
            o_status_d = nftk_pkg::STATUS_NEW;
          end else begin
            o_cnt_d    = '0;
            o_status_d = nftk_pkg::STATUS_DROPPED;
          end
          o_valid_d = 1'b1;
          state_d   = ST_OUT;
        end
      end
      ST_RANK: begin
        if (pend_q && eligible && (!found_q || rd_cnt_q > best_cnt_q)) begin
          found_d    = 1'b1;
          best_cnt_d = rd_cnt_q;
          best_idx_d = pidx_q;
          best_hi_d  = rd_hi_q;
          best_lo_d  = rd_lo_q;
        end
        if (scan_end) begin
          o_valid_d   = 1'b1;
          o_status_d  = nftk_pkg::STATUS_TOP;
          o_hi_d      = best_hi_q;
          o_lo_d      = best_lo_q;
          o_cnt_d     = best_cnt_q;
          o_rank_d    = nftk_pkg::RANK_W'(n_q);
          o_last_d    = rank_last;
          more_d      = !rank_last;
          prev_cnt_d  = best_cnt_q;
          prev_idx_d  = best_idx_q;
          have_prev_d = 1'b1;
          found_d     = 1'b0;
          n_d         = n_inc;
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          o_valid_d = 1'b0;
          iss_d     = '0;
          pend_d    = 1'b0;
          state_d   = more_q ? ST_RANK : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      total_q     <= '0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      more_q      <= 1'b0;
      n_q         <= '0;
      found_q     <= 1'b0;
      have_prev_q <= 1'b0;
      o_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      total_q     <= total_d;
      iss_q       <= iss_d;
      pend_q      <= pend_d;
      more_q      <= more_d;
      n_q         <= n_d;
      found_q     <= found_d;
      have_prev_q <= have_prev_d;
      o_valid_q   <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    name_hi_q  <= name_hi_d;
    name_lo_q  <= name_lo_d;
    best_cnt_q <= best_cnt_d;
    best_idx_q <= best_idx_d;
    best_hi_q  <= best_hi_d;
    best_lo_q  <= best_lo_d;
    prev_cnt_q <= prev_cnt_d;
    prev_idx_q <= prev_idx_d;
    o_last_q   <= o_last_d;
    o_status_q <= o_status_d;
    o_hi_q     <= o_hi_d;
    o_lo_q     <= o_lo_d;
    o_cnt_q    <= o_cnt_d;
    o_rank_q   <= o_rank_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_key_en) begin
      key_hi_mem[wr_addr] <= name_hi_q;
      key_lo_mem[wr_addr] <= name_lo_q;
    end
    if (wr_cnt_en) begin
      count_mem[wr_addr] <= wr_cnt;
    end
    rd_hi_q  <= key_hi_mem[rd_addr];
    rd_lo_q  <= key_lo_mem[rd_addr];
    rd_cnt_q <= count_mem[rd_addr];
  end

endmodule
`default_nettype wire

[tb/sv/name_frequency_table_top_k_core_tb.sv]
// Self-checking testbench for the name frequency table with its top-k report.
module name_frequency_table_top_k_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned POOL_NAMES    = 80;

  typedef struct {
    nftk_pkg::status_e                 status;
    logic [nftk_pkg::NAME_W-1:0]       name_hi;
    logic [nftk_pkg::NAME_W-1:0]       name_lo;
    logic [nftk_pkg::CNT_W-1:0]        count;
    logic [nftk_pkg::RANK_W-1:0]       rank;
    logic [nftk_pkg::CNT_W-1:0]        total;
    logic                              last;
  } table_out_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  logic [nftk_pkg::IN_DATA_W-1:0]      s_axis_tdata;
  logic                                s_axis_tuser;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  logic [nftk_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
  logic [nftk_pkg::STATUS_W-1:0]       m_axis_tuser;
  logic                                m_axis_tlast;

  // Shadow copy of the table, indexed like the block's own entries.
  logic [2*nftk_pkg::NAME_W-1:0]       tbl_name [TABLE_ENTRIES];
  logic [nftk_pkg::CNT_W-1:0]          tbl_cnt  [TABLE_ENTRIES];
  int unsigned                         tbl_used;
  logic [nftk_pkg::CNT_W-1:0]          seen_total;

  table_out_t                          awaited_outputs [$];
  logic [2*nftk_pkg::NAME_W-1:0]       name_pool [POOL_NAMES];
  int unsigned                         mismatches;
  int unsigned                         cycle_count;
  int unsigned                         sender_idle_pct;
  int unsigned                         recv_stall_pct;

  name_frequency_table_top_k_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // A name ends at its first zero byte; everything after it is cleared.
  function automatic logic [2*nftk_pkg::NAME_W-1:0] canonical_name(
    logic [2*nftk_pkg::NAME_W-1:0] raw);
    logic [2*nftk_pkg::NAME_W-1:0] name;
    bit ended;
    name  = raw;
    ended = 1'b0;
    for (int k = 0; k < 16; k++) begin
      if (k >= nftk_pkg::NAME_BYTES || name[127-8*k -: 8] == 8'h00) ended = 1'b1;
      if (ended) name[127-8*k -: 8] = 8'h00;
    end
    return name;
  endfunction

  function automatic void predict_table_outputs(nftk_pkg::req_e req,
                                                logic [2*nftk_pkg::NAME_W-1:0] raw);
    logic [2*nftk_pkg::NAME_W-1:0] name;
    int hit;
    int best;
    int want_n;
    bit taken [TABLE_ENTRIES];
    table_out_t r;
    r.rank = '0;
    r.last = 1'b1;
    if (req == nftk_pkg::REQ_RECORD) begin
      name = canonical_name(raw);
      if (seen_total != nftk_pkg::CNT_MAX) seen_total++;
      hit = -1;
      for (int i = 0; i < tbl_used; i++) begin
        if (hit < 0 && tbl_name[i] == name) hit = i;
      end
      r.name_hi = name[127:64];
      r.name_lo = name[63:0];
      if (hit >= 0) begin
        if (tbl_cnt[hit] != nftk_pkg::CNT_MAX) tbl_cnt[hit]++;
        r.status = nftk_pkg::STATUS_MATCH;
        r.count  = tbl_cnt[hit];
      end else if (tbl_used < TABLE_ENTRIES) begin
        tbl_name[tbl_used] = name;
        tbl_cnt[tbl_used]  = 1;
        tbl_used++;
        r.status = nftk_pkg::STATUS_NEW;
        r.count  = 1;
      end else begin
        r.status = nftk_pkg::STATUS_DROPPED;
        r.count  = '0;
      end
      r.total = seen_total;
      awaited_outputs.push_back(r);
    end else if (tbl_used == 0) begin
      r.status  = nftk_pkg::STATUS_EMPTY;
      r.name_hi = '0;
      r.name_lo = '0;
      r.count   = '0;
      r.total   = seen_total;
      awaited_outputs.push_back(r);
    end else begin
      foreach (taken[i]) taken[i] = 1'b0;
      want_n = (tbl_used < nftk_pkg::TOP_COUNT) ? tbl_used : nftk_pkg::TOP_COUNT;
      for (int n = 0; n < want_n; n++) begin
        best = -1;
        // Strictly greater, so the earlier entry keeps a tie.
        for (int i = 0; i < tbl_used; i++) begin
          if (!taken[i] && (best < 0 || tbl_cnt[i] > tbl_cnt[best])) best = i;
        end
        taken[best] = 1'b1;
        r.status  = nftk_pkg::STATUS_TOP;
        r.name_hi = tbl_name[best][127:64];
        r.name_lo = tbl_name[best][63:0];
        r.count   = tbl_cnt[best];
        r.rank    = nftk_pkg::RANK_W'(n);
        r.total   = seen_total;
        r.last    = (n == want_n - 1);
        awaited_outputs.push_back(r);
      end
    end
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : check_outputs
    table_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_outputs.size() == 0) begin
        $error("result item with nothing outstanding, status %0d", m_axis_tuser);
        mismatches++;
      end else begin
        want = awaited_outputs.pop_front();
        check_field("status", want.status, m_axis_tuser);
        check_field("out_name_high", want.name_hi, m_axis_tdata[63:0]);
        check_field("out_name_low", want.name_lo, m_axis_tdata[127:64]);
        check_field("entry_count", want.count, m_axis_tdata[159:128]);
        check_field("rank", want.rank, m_axis_tdata[162:160]);
        check_field("total_seen", want.total, m_axis_tdata[194:163]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
  end

  function automatic logic [2*nftk_pkg::NAME_W-1:0] random_bits();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [2*nftk_pkg::NAME_W-1:0] make_name(int len);
    logic [2*nftk_pkg::NAME_W-1:0] name;
    name = '0;
    for (int k = 0; k < len; k++) name[127-8*k -: 8] = 8'($urandom_range(255, 1));
    return name;
  endfunction

  // Fills the bytes behind the terminating zero with junk.
  function automatic logic [2*nftk_pkg::NAME_W-1:0] with_padding_noise(
    logic [2*nftk_pkg::NAME_W-1:0] name);
    logic [2*nftk_pkg::NAME_W-1:0] noisy;
    bit ended;
    noisy = name;
    ended = 1'b0;
    for (int k = 0; k < 16; k++) begin
      if (ended) noisy[127-8*k -: 8] = 8'($urandom);
      else if (noisy[127-8*k -: 8] == 8'h00) ended = 1'b1;
    end
    return noisy;
  endfunction

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    sender_idle_pct = send_pct;
    recv_stall_pct  = recv_pct;
  endtask

  task automatic send_item(nftk_pkg::req_e req, logic [2*nftk_pkg::NAME_W-1:0] name);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {name[63:0], name[127:64]};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_table_outputs(req, name);
  endtask

  task automatic test_empty_report();
    send_item(nftk_pkg::REQ_REPORT, '0);
    send_item(nftk_pkg::REQ_REPORT, '1);
  endtask

  task automatic test_canonical_names();
    send_item(nftk_pkg::REQ_RECORD, '0);
    send_item(nftk_pkg::REQ_RECORD, {64'h00FF_FFFF_FFFF_FFFF, 64'h1234_5678_9ABC_DEF0});
    send_item(nftk_pkg::REQ_RECORD, '1);
    send_item(nftk_pkg::REQ_REPORT, random_bits());
    send_item(nftk_pkg::REQ_RECORD, {64'h4142_4300_DEAD_BEEF, 64'hFFFF_FFFF_FFFF_FFFF});
    send_item(nftk_pkg::REQ_RECORD, {64'h4142_4300_0000_0000, 64'h0});
    send_item(nftk_pkg::REQ_RECORD, {64'h4142_4344_4546_4748, 64'h4900_1234_5678_9ABC});
    send_item(nftk_pkg::REQ_RECORD, {64'h4142_4344_4546_4748, 64'h4900_0000_0000_0001});
    send_item(nftk_pkg::REQ_RECORD, {64'h0102_0304_0506_0708, 64'h090A_0B0C_0D0E_0F10});
    send_item(nftk_pkg::REQ_RECORD, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00});
    send_item(nftk_pkg::REQ_REPORT, '0);
  endtask

  task automatic test_tie_ranking();
    send_item(nftk_pkg::REQ_RECORD, '1);
    repeat (2) begin
      send_item(nftk_pkg::REQ_RECORD, {64'h0102_0304_0506_0708, 64'h090A_0B0C_0D0E_0F10});
    end
    send_item(nftk_pkg::REQ_REPORT, random_bits());
    // The short name now ties the sixteen-byte one and sits earlier in the table.
    send_item(nftk_pkg::REQ_RECORD, {64'h4142_4300_0000_0000, 64'h0});
    send_item(nftk_pkg::REQ_REPORT, random_bits());
    send_item(nftk_pkg::REQ_RECORD, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00});
    send_item(nftk_pkg::REQ_REPORT, random_bits());
  endtask

  task automatic test_random_traffic(int n_items, int pool_span);
    int pick;
    logic [2*nftk_pkg::NAME_W-1:0] name;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_item(nftk_pkg::REQ_REPORT, random_bits());
      end else if (pick < 22) begin
        send_item(nftk_pkg::REQ_RECORD, random_bits());
      end else begin
        name = name_pool[$urandom_range(pool_span - 1)];
        if ($urandom_range(3) == 0) name = with_padding_noise(name);
        send_item(nftk_pkg::REQ_RECORD, name);
      end
    end
  endtask

  task automatic test_drain_pause();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (awaited_outputs.size() != 0);
    send_item(nftk_pkg::REQ_REPORT, random_bits());
  endtask

  task automatic test_table_full();
    while (tbl_used < TABLE_ENTRIES) send_item(nftk_pkg::REQ_RECORD, make_name(16));
    repeat (3) send_item(nftk_pkg::REQ_RECORD, make_name(16));
    send_item(nftk_pkg::REQ_RECORD, with_padding_noise(make_name(5)));
    send_item(nftk_pkg::REQ_RECORD, tbl_name[TABLE_ENTRIES-1]);
    send_item(nftk_pkg::REQ_REPORT, random_bits());
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = 1'b0;
    tbl_used        = 0;
    seen_total      = '0;
    mismatches      = 0;
    cycle_count     = 0;
    foreach (name_pool[i]) name_pool[i] = make_name($urandom_range(16, 1));
    set_idling(20, 73);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_report();
    test_canonical_names();
    test_tie_ranking();
    test_random_traffic(130, 40);
    test_drain_pause();

    set_idling(73, 20);
    test_table_full();
    test_random_traffic(110, POOL_NAMES);

    set_idling(0, 0);
    test_random_traffic(150, POOL_NAMES);

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (awaited_outputs.size() != 0);
    // A full report pass over the whole table is the longest the block stays busy.
    repeat (400) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
design/nftk_pkg.sv
design/name_frequency_table_top_k_core.sv
tb/sv/name_frequency_table_top_k_core_tb.sv
